// File: src/xbrs_pkg.sv
// ----------------------------------------------------------------------------
// xbrs_pkg: shared types and constants of the bounded random source
// Opcodes, controller states, command/status structs and generator constants.
// ----------------------------------------------------------------------------
package xbrs_pkg;

  localparam logic [63:0] GOLDEN_INC = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B  = 64'h94d049bb133111eb;

  typedef enum logic [1:0] {
    OP_U64 = 2'd0,
    OP_U32 = 2'd1,
    OP_S64 = 2'd2,
    OP_S32 = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_SEED,     // start SplitMix64 expansion
    ST_MIX,      // SplitMix64 multiply chain
    ST_IDLE,
    ST_SETUP,    // latch range, check full width
    ST_THR,      // threshold remainder
    ST_DRAW,     // generator draw (multiplies)
    ST_CHECK,    // compare against threshold
    ST_MOD,      // value remainder
    ST_DONE
  } state_e;

  typedef struct packed {
    logic seed_start;  // load seed counter, begin expansion
    logic mix_step;    // advance SplitMix64 chain one stage
    logic setup;       // latch request
    logic thr_start;   // start remainder of threshold
    logic draw_step;   // advance draw pipeline one stage
    logic mod_start;   // start remainder of draw
    logic finish;      // form result into output register
  } cmd_t;

  typedef struct packed {
    logic mix_done;    // all four words loaded
    logic full;        // limit is all ones
    logic div_busy;
    logic draw_done;
    logic accept;      // draw at or above threshold
  } sts_t;

endpackage

// File: src/xoshiro_bounded_random_source.sv
// ----------------------------------------------------------------------------
// xoshiro_bounded_random_source: bounded xoshiro256** random source
// Seeded by SplitMix64; returns draws bounded by modulo rejection.
// ----------------------------------------------------------------------------
// channel  | dir | handshake              | content
// cfg      | in  | cfg_valid_i/ready_o    | seed, 64 bits
// s_axis   | in  | s_axis_tvalid/tready   | op, bound, range_low, range_high
// m_axis   | out | m_axis_tvalid/tready   | value, 64 bits
//
// With no rejection, two remainders (threshold, then value) run back to back
// in the radix-2 divider before m_axis_tvalid rises; the draw hides under the
// first. A full-width limit skips the value remainder; each rejection adds
// another draw and check. After reset and after each seed transfer the
// SplitMix64 chain holds requests off. A finished result holds in the output
// register until taken; the next request may start meanwhile and holds in its
// last step.
module xoshiro_bounded_random_source (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [63:0]   cfg_data_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [199:0]  s_axis_tdata,   // op[1:0], bound[65:2], range_low[129:66],
                                        // range_high[193:130], zero fill
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [63:0]   m_axis_tdata    // value[63:0]
);
  import xbrs_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [63:0] seed_q;

  // hold the seed; reset seed is zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) seed_q <= '0;
    else if (cfg_valid_i && cfg_ready_o) seed_q <= cfg_data_i;
  end

  xbrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  xbrs_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .seed_i      (seed_q),
    .op_i        (s_axis_tdata[1:0]),
    .bound_i     (s_axis_tdata[65:2]),
    .range_low_i (s_axis_tdata[129:66]),
    .range_high_i(s_axis_tdata[193:130]),
    .value_o     (m_axis_tdata)
  );
endmodule

// File: src/xbrs_divider.sv
// ----------------------------------------------------------------------------
// xbrs_divider: radix-2 restoring remainder unit
// Computes num mod den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module xbrs_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        busy_o,
  output logic [63:0] rem_o
);
  logic [63:0] num_q, num_d;
  logic [64:0] rem_q, rem_d;
  logic [63:0] den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [64:0] shifted;
  logic [64:0] diff;

  always_comb begin
    shifted = {rem_q[63:0], num_q[63]};
    diff    = shifted - {1'b0, den_q};
    num_d = num_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    if (start_i) begin
      num_d = num_i;
      den_d = den_i;
      rem_d = '0;
      cnt_d = 7'd64;
    end else if (cnt_q != 7'd0) begin
      num_d = {num_q[62:0], 1'b0};
      rem_d = diff[64] ? shifted : diff;
      cnt_d = cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = (cnt_q != 7'd0);
  assign rem_o  = rem_q[63:0];
endmodule

// File: src/xbrs_datapath.sv
// ----------------------------------------------------------------------------
// xbrs_datapath: generator state, seed expansion and range arithmetic
// Holds xoshiro256** words, SplitMix64 chain, range/threshold and result.
// ----------------------------------------------------------------------------
module xbrs_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  xbrs_pkg::cmd_t       cmd_i,
  output xbrs_pkg::sts_t       sts_o,
  input  logic [63:0]          seed_i,
  input  logic [1:0]           op_i,
  input  logic [63:0]          bound_i,
  input  logic [63:0]          range_low_i,
  input  logic [63:0]          range_high_i,
  output logic [63:0]          value_o
);
  import xbrs_pkg::*;

  logic [63:0] s_q [4];
  logic [63:0] s_d [4];
  logic [63:0] ctr_q, ctr_d;
  logic [63:0] z_q, z_d;
  logic [63:0] acc_q, acc_d;   // partial products of one 64-bit multiply
  logic [3:0]  mst_q, mst_d;   // stage within one SplitMix64 output
  logic [1:0]  widx_q, widx_d;
  logic        mix_done_q, mix_done_d;

  logic        w32_q;
  logic [63:0] range_q, low_q, x_q, y_q;
  logic [1:0]  dst_q;
  logic        draw_done;
  logic        is32_in;
  logic [63:0] limit_in;
  logic        full_q;
  logic [1:0]  op_q;

  logic [63:0] div_num, div_den, rem;
  logic        div_start, div_busy;
  logic [31:0] sum32;
  logic [63:0] bnd;

  // SplitMix64: stage 0 add, 1 xor-shift, 2-4 mul A, 5 xor-shift, 6-8 mul B,
  // 9 xor-shift and store. Each multiply is split into 32x32 products: the low product,
  // then the two cross products, of which only the low 32 bits count.
  always_comb begin
    ctr_d = ctr_q;
    z_d = z_q;
    acc_d = acc_q;
    mst_d = mst_q;
    widx_d = widx_q;
    mix_done_d = mix_done_q;
    for (int i = 0; i < 4; i++) s_d[i] = s_q[i];
    if (cmd_i.seed_start) begin
      ctr_d = seed_i;
      mst_d = 4'd0;
      widx_d = 2'd0;
      mix_done_d = 1'b0;
    end else if (cmd_i.mix_step) begin
      mst_d = mst_q + 4'd1;
      case (mst_q)
        4'd0: begin
          ctr_d = ctr_q + GOLDEN_INC;
          z_d = ctr_q + GOLDEN_INC;
        end
        4'd1: z_d = z_q ^ (z_q >> 30);
        4'd2: acc_d = {32'd0, z_q[31:0]} * {32'd0, MIX_MUL_A[31:0]};
        4'd3: acc_d = acc_q + {z_q[31:0] * MIX_MUL_A[63:32], 32'd0};
        4'd4: z_d = acc_q + {z_q[63:32] * MIX_MUL_A[31:0], 32'd0};
        4'd5: z_d = z_q ^ (z_q >> 27);
        4'd6: acc_d = {32'd0, z_q[31:0]} * {32'd0, MIX_MUL_B[31:0]};
        4'd7: acc_d = acc_q + {z_q[31:0] * MIX_MUL_B[63:32], 32'd0};
        4'd8: z_d = acc_q + {z_q[63:32] * MIX_MUL_B[31:0], 32'd0};
        default: begin
          s_d[widx_q] = z_q ^ (z_q >> 31);
          mst_d = 4'd0;
          widx_d = widx_q + 2'd1;
          if (widx_q == 2'd3) mix_done_d = 1'b1;
        end
      endcase
    end else if (cmd_i.draw_step && dst_q == 2'd2) begin
      s_d[2] = s_q[2] ^ s_q[0];
      s_d[3] = s_q[3] ^ s_q[1];
      s_d[1] = s_q[1] ^ s_q[2] ^ s_q[0];
      s_d[0] = s_q[0] ^ s_q[3] ^ s_q[1];
      s_d[2] = s_d[2] ^ (s_q[1] << 17);
      s_d[3] = {s_d[3][18:0], s_d[3][63:19]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mst_q <= '0;
      widx_q <= '0;
      mix_done_q <= 1'b0;
      dst_q <= '0;
    end else begin
      mst_q <= mst_d;
      widx_q <= widx_d;
      mix_done_q <= mix_done_d;
      if (cmd_i.setup || cmd_i.draw_step && dst_q == 2'd2) dst_q <= 2'd0;
      else if (cmd_i.draw_step) dst_q <= dst_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    ctr_q <= ctr_d;
    z_q <= z_d;
    acc_q <= acc_d;
    for (int i = 0; i < 4; i++) s_q[i] <= s_d[i];
  end

  // request decode
  assign is32_in  = (op_i == OP_U32) || (op_i == OP_S32);
  assign limit_in = (op_i == OP_U64) ? bound_i :
                    (op_i == OP_U32) ? {32'd0, bound_i[31:0]} :
                    (op_i == OP_S64) ? range_high_i - range_low_i :
                    {32'd0, range_high_i[31:0] - range_low_i[31:0]};

  // draw: stage 0 mul 5, stage 1 rotate and mul 9, stage 2 take result and update state
  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      op_q <= op_i;
      w32_q <= is32_in;
      low_q <= range_low_i;
      full_q <= is32_in ? (limit_in[31:0] == 32'hffff_ffff) : (limit_in == '1);
      range_q <= is32_in ? {32'd0, limit_in[31:0] + 32'd1} : limit_in + 64'd1;
    end
    if (cmd_i.draw_step) begin
      case (dst_q)
        2'd0: y_q <= s_q[1] * 64'd5;
        2'd1: y_q <= {y_q[56:0], y_q[63:57]} * 64'd9;
        default: x_q <= w32_q ? {32'd0, y_q[63:32]} : y_q;
      endcase
    end
  end

  // remainder unit shared between threshold and final value
  assign div_start = cmd_i.thr_start || cmd_i.mod_start;
  assign div_den   = range_q;
  assign div_num   = cmd_i.mod_start ? x_q :
                     (w32_q ? {32'd0, 32'd0 - range_q[31:0]} : 64'd0 - range_q);

  xbrs_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .rem_o  (rem)
  );

  // capture threshold when its remainder finishes (before the first check)
  logic thr_pend_q;
  logic [63:0] thr_r_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) thr_pend_q <= 1'b0;
    else if (cmd_i.thr_start) thr_pend_q <= 1'b1;
    else if (thr_pend_q && !div_busy) thr_pend_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (thr_pend_q && !div_busy) thr_r_q <= rem;
  end

  assign draw_done = (dst_q == 2'd0) && !cmd_i.draw_step;
  assign bnd = full_q ? x_q : rem;
  assign sum32 = low_q[31:0] + bnd[31:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      case (op_q)
        OP_U64: value_o <= bnd;
        OP_U32: value_o <= {32'd0, bnd[31:0]};
        OP_S64: value_o <= low_q + bnd;
        default: value_o <= {{32{sum32[31]}}, sum32};
      endcase
    end
  end

  assign sts_o.mix_done  = mix_done_q;
  assign sts_o.full      = full_q;
  assign sts_o.div_busy  = div_busy || thr_pend_q;
  assign sts_o.draw_done = draw_done;
  assign sts_o.accept    = (x_q >= thr_r_q);
endmodule

// File: src/xbrs_ctrl.sv
// ----------------------------------------------------------------------------
// xbrs_ctrl: controller state machine
// Sequences seed expansion, threshold, draws with rejection and result.
// ----------------------------------------------------------------------------
module xbrs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output xbrs_pkg::cmd_t cmd_o,
  input  xbrs_pkg::sts_t sts_i
);
  import xbrs_pkg::*;

  state_e state_q, state_d;
  logic [1:0] dcnt_q, dcnt_d;
  logic out_valid_q, out_valid_d;
  logic out_free;   // output register empty or emptied at this edge

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_SEED:  state_d = ST_MIX;
      ST_MIX:   if (sts_i.mix_done) state_d = ST_IDLE;
      ST_IDLE: begin
        if (cfg_valid_i) state_d = ST_SEED;
        else if (in_valid_i) state_d = ST_SETUP;
      end
      ST_SETUP: state_d = ST_THR;
      ST_THR:   state_d = ST_DRAW;
      ST_DRAW:  if (dcnt_q == 2'd2) state_d = ST_CHECK;
      ST_CHECK: begin
        if (!sts_i.div_busy) begin
          if (sts_i.full) state_d = ST_DONE;
          else if (sts_i.accept) state_d = ST_MOD;
          else state_d = ST_DRAW;
        end
      end
      ST_MOD:   state_d = ST_DONE;
      ST_DONE:  if (!sts_i.div_busy && out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    dcnt_d = '0;
    cfg_ready_o = 1'b0;
    in_ready_o = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_SEED: cmd_o.seed_start = 1'b1;
      ST_MIX:  cmd_o.mix_step = !sts_i.mix_done;
      ST_IDLE: begin
        cfg_ready_o = 1'b1;
        in_ready_o = !cfg_valid_i;
        cmd_o.setup = in_valid_i && in_ready_o;
      end
      ST_THR:  cmd_o.thr_start = 1'b1;
      ST_DRAW: begin
        cmd_o.draw_step = 1'b1;
        dcnt_d = dcnt_q + 2'd1;
      end
      ST_MOD:  cmd_o.mod_start = 1'b1;
      ST_DONE: begin
        cmd_o.finish = !sts_i.div_busy && out_free;
        if (!sts_i.div_busy && out_free) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SEED;
      dcnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      dcnt_q <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
endmodule

// File: src/xbrs_checker.sv
// ----------------------------------------------------------------------------
// xbrs_checker: port-level checks of the bounded random source
// Watches handshakes and result holding on the top-level ports.
// ----------------------------------------------------------------------------
module xbrs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !cfg_ready_o)
    else $error("ready held high right after a request transfer");

  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> !s_axis_tready && !cfg_ready_o)
    else $error("ready held high right after a seed transfer");

  a_cfg_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |-> !(s_axis_tvalid && s_axis_tready))
    else $error("seed write and request in same cycle");
endmodule

bind xoshiro_bounded_random_source xbrs_checker u_xbrs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_valid_i  (cfg_valid_i),
  .cfg_ready_o  (cfg_ready_o),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
